/* rtl/bvot_pkg.sv */
// ============================================================================
// bvot_pkg
// Shared widths, codes and stage types of the bounding volume overlap test.
// ============================================================================
`default_nettype none

package bvot_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int BB_W        = COORD_WIDTH + 3;
  localparam int SQ_W        = 2 * COORD_WIDTH + 1;
  localparam int SUM_W       = SQ_W + 2;
  localparam int NUM_COORD   = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic CMD_POINT   = 1'b0;
  localparam logic CMD_REGION  = 1'b1;
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z1   = 3'd6;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic                     dist_mode;
    logic                     strict;
    logic                     flag_hit;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [DIFF_W-1:0] r;
  } prep_t;

  typedef struct packed {
    logic            dist_mode;
    logic            strict;
    logic            flag_hit;
    logic [SQ_W-1:0] sx;
    logic [SQ_W-1:0] sy;
    logic [SQ_W-1:0] sz;
    logic [SQ_W-1:0] sr;
  } sq_t;

endpackage

`default_nettype wire

/* rtl/bvot_prep.sv */
// ============================================================================
// bvot_prep
// Test selection: box bound checks and the axis deltas and radius term for
// the distance based tests (sphere-sphere, point-sphere, clamped sphere-box).
// ============================================================================
`default_nettype none

module bvot_prep import bvot_pkg::*; (
  input  wire logic   stored_kind,
  input  wire coord_t stored_c [NUM_COORD],
  input  wire logic   cmd,
  input  wire logic   query_kind,
  input  wire coord_t query_c [NUM_COORD],
  output prep_t       prep
);

  coord_t                   cs   [3];
  coord_t                   bmin [3];
  coord_t                   bmax [3];
  coord_t                   t    [3];
  logic signed [DIFF_W-1:0] d_sb [3];
  logic signed [DIFF_W-1:0] d_cc [3];
  logic signed [BB_W-1:0]   bb_d [3];
  logic signed [BB_W-1:0]   bb_e [3];
  logic                     pb_ok;
  logic                     bb_ok;
  logic signed [DIFF_W-1:0] r_sb;
  logic signed [DIFF_W-1:0] r_ss;
  logic signed [DIFF_W-1:0] r_pt;

  always_comb begin
    pb_ok = 1'b1;
    bb_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (stored_kind == KIND_SPHERE) begin
        cs[i]   = stored_c[i];
        bmin[i] = query_c[i];
        bmax[i] = query_c[i+3];
      end else begin
        cs[i]   = query_c[i];
        bmin[i] = stored_c[i];
        bmax[i] = stored_c[i+3];
      end
      t[i] = (cs[i] < bmax[i]) ? cs[i] : bmax[i];
      if (bmin[i] > t[i]) begin
        t[i] = bmin[i];
      end
      d_sb[i] = DIFF_W'(t[i]) - DIFF_W'(cs[i]);
      d_cc[i] = DIFF_W'(stored_c[i]) - DIFF_W'(query_c[i]);

      if (query_c[i] < stored_c[i] || query_c[i] > stored_c[i+3]) begin
        pb_ok = 1'b0;
      end

      bb_d[i] = (BB_W'(stored_c[i]) + BB_W'(stored_c[i+3]))
              - (BB_W'(query_c[i]) + BB_W'(query_c[i+3]));
      bb_e[i] = (BB_W'(stored_c[i+3]) - BB_W'(stored_c[i]))
              + (BB_W'(query_c[i+3]) - BB_W'(query_c[i]));
      if (bb_d[i] > bb_e[i] || -bb_d[i] > bb_e[i]) begin
        bb_ok = 1'b0;
      end
    end

    r_pt = DIFF_W'(stored_c[3]);
    r_ss = DIFF_W'(stored_c[3]) + DIFF_W'(query_c[3]);
    r_sb = (stored_kind == KIND_SPHERE) ? DIFF_W'(stored_c[3]) : DIFF_W'(query_c[3]);

    prep.dist_mode = 1'b1;
    prep.strict    = 1'b0;
    prep.flag_hit  = 1'b0;
    prep.dx        = d_cc[0];
    prep.dy        = d_cc[1];
    prep.dz        = d_cc[2];
    prep.r         = r_pt;

    if (cmd == CMD_POINT) begin
      if (stored_kind == KIND_BOX) begin
        prep.dist_mode = 1'b0;
        prep.flag_hit  = pb_ok;
      end
    end else if (stored_kind == KIND_BOX && query_kind == KIND_BOX) begin
      prep.dist_mode = 1'b0;
      prep.flag_hit  = bb_ok;
    end else if (stored_kind == KIND_SPHERE && query_kind == KIND_SPHERE) begin
      prep.r = r_ss;
    end else begin
      prep.strict = 1'b1;
      prep.dx     = d_sb[0];
      prep.dy     = d_sb[1];
      prep.dz     = d_sb[2];
      prep.r      = r_sb;
    end
  end

endmodule

`default_nettype wire

/* rtl/bvot_square.sv */
// ============================================================================
// bvot_square
// Squares the three axis deltas and the radius term.
// ============================================================================
`default_nettype none

module bvot_square import bvot_pkg::*; (
  input  wire prep_t prep,
  output sq_t        sq
);

  logic signed [2*DIFF_W-1:0] px;
  logic signed [2*DIFF_W-1:0] py;
  logic signed [2*DIFF_W-1:0] pz;
  logic signed [2*DIFF_W-1:0] pr;

  assign px = prep.dx * prep.dx;
  assign py = prep.dy * prep.dy;
  assign pz = prep.dz * prep.dz;
  assign pr = prep.r * prep.r;

  assign sq.dist_mode = prep.dist_mode;
  assign sq.strict    = prep.strict;
  assign sq.flag_hit  = prep.flag_hit;
  assign sq.sx        = px[SQ_W-1:0];
  assign sq.sy        = py[SQ_W-1:0];
  assign sq.sz        = pz[SQ_W-1:0];
  assign sq.sr        = pr[SQ_W-1:0];

endmodule

`default_nettype wire

/* rtl/bvot_compare.sv */
// ============================================================================
// bvot_compare
// Sums the squared deltas and compares against the squared radius term; box tests pass their flag through.
// ============================================================================
`default_nettype none

module bvot_compare import bvot_pkg::*; (
  input  wire sq_t   sq,
  output logic       hit
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] rsq;

  assign sum = SUM_W'(sq.sx) + SUM_W'(sq.sy) + SUM_W'(sq.sz);
  assign rsq = SUM_W'(sq.sr);

  always_comb begin
    if (!sq.dist_mode) begin
      hit = sq.flag_hit;
    end else if (sq.strict) begin
      hit = (sum < rsq);
    end else begin
      hit = (sum <= rsq);
    end
  end

endmodule

`default_nettype wire

/* rtl/bounding_volume_overlap_test.sv */
// ============================================================================
// bounding_volume_overlap_test
// Point containment and region intersection of a query against one stored
// axis-aligned box or sphere, signed Q8.8 coordinates.
// ============================================================================
//  port group | dir | content
//  in_*       | in  | tuser: cmd, query_kind; tdata: query x0,y0,z0,x1,y1,z1
//  out_*      | out | tdata: hit (bit 0)
//  cfg_*      | in  | stored_kind, stored x0,y0,z0,x1,y1,z1 by index
//
//  One item per cycle unless the output stalls; each stage below is registered.
//  Stages: input register, test select, squares, sum/compare into output.
//  Each stage holds when the next is full and stalled; bubbles are squeezed.
//  Reset clears stage valids and the stored volume (zero-size box at origin).
// ============================================================================
`default_nettype none

module bounding_volume_overlap_test import bvot_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [95:0]            in_tdata,   // query_x0,y0,z0,x1,y1,z1
  input  wire logic [1:0]             in_tuser,   // cmd, query_kind
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [7:0]                  out_tdata,  // hit, zero fill
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_WIDTH-1:0] cfg_wdata
);

  logic   kind_r;
  coord_t stc_r [NUM_COORD];

  logic   v0_r, v1_r, v2_r, v3_r;
  logic   rdy1, rdy2, rdy3;
  logic   cmd_r, qkind_r;
  coord_t qc_r [NUM_COORD];
  prep_t  prep_nxt, prep_r;
  sq_t    sq_nxt, sq_r;
  logic   hit_nxt, hit_r;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_BOX;
      for (int i = 0; i < NUM_COORD; i++) begin
        stc_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_KIND) begin
        kind_r <= cfg_wdata[0];
      end else if (cfg_index >= REG_X0 && cfg_index <= REG_Z1) begin
        stc_r[cfg_index - REG_X0] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy1)      v1_r <= v0_r;
      if (rdy2)      v2_r <= v1_r;
      if (rdy3)      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      cmd_r   <= in_tuser[0];
      qkind_r <= in_tuser[1];
      for (int i = 0; i < NUM_COORD; i++) begin
        qc_r[i] <= in_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      end
    end
    if (rdy1) prep_r <= prep_nxt;
    if (rdy2) sq_r   <= sq_nxt;
    if (rdy3) hit_r  <= hit_nxt;
  end

  bvot_prep u_prep (
    .stored_kind (kind_r),
    .stored_c    (stc_r),
    .cmd         (cmd_r),
    .query_kind  (qkind_r),
    .query_c     (qc_r),
    .prep        (prep_nxt)
  );

  bvot_square u_square (
    .prep (prep_r),
    .sq   (sq_nxt)
  );

  bvot_compare u_compare (
    .sq  (sq_r),
    .hit (hit_nxt)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'd0, hit_r};

endmodule

`default_nettype wire
